// ===== hw/rtl/hebd_pkg.sv =====
// Shared types and constants for the bf16 exponent Huffman decoder.
package hebd_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_WR_TABLE = 2'd0,
    OP_PUSH     = 2'd1,
    OP_DECODE   = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_LEN,
    S_OUT
  } state_t;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned HELD_W = 7;

  localparam logic [HELD_W-1:0] FULL_LIMIT    = 7'd56;
  localparam logic [7:0]        LINK_MIN      = 8'd240;
  localparam logic [1:0]        LEVEL_MAX     = 2'd3;
  localparam logic [3:0]        TBL_CNT_RESET = 4'd4;

  // Commands to the bit accumulator
  typedef struct packed {
    logic       push;
    logic       drop;
    logic [7:0] push_byte;
    logic [7:0] drop_len;
  } acc_cmd_t;

endpackage

// ===== hw/rtl/hebd_lut_mem.sv =====
// Byte lookup memory with separate write and read ports and registered read data.
module hebd_lut_mem #(
  parameter int unsigned DEPTH = 2304,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/hebd_bit_acc.sv =====
// Left-aligned 64-bit bit accumulator with byte push and variable drop.
module hebd_bit_acc (
  input  logic               clk,
  input  logic               rst_n,
  input  hebd_pkg::acc_cmd_t cmd,
  input  logic [1:0]         byte_sel,
  output logic [7:0]         byte_out,
  output logic               full
);

  import hebd_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [ACC_W-1:0]  push_word;
  logic [5:0]        byte_lo;

  // Incoming byte placed just below the held bits
  assign push_word = {cmd.push_byte, {(ACC_W-8){1'b0}}} >> held_r;

  // Next accumulator contents
  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    if (cmd.push) begin
      acc_nxt  = acc_r | push_word;
      held_nxt = held_r + 7'd8;
    end else if (cmd.drop) begin
      if (cmd.drop_len >= 8'(ACC_W)) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_r << cmd.drop_len[5:0];
      end
      if (cmd.drop_len >= 8'(held_r)) begin
        held_nxt = '0;
      end else begin
        held_nxt = 7'(8'(held_r) - cmd.drop_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  // Byte window: sel 0 is the top byte
  assign byte_lo  = 6'(ACC_W - 8) - {1'b0, byte_sel, 3'b000};
  assign byte_out = acc_r[byte_lo +: 8];
  assign full     = held_r > FULL_LIMIT;

endmodule

// ===== hw/rtl/huffman_exponent_bf16_decoder_unit.sv =====
// Top level: sequencer for table-chained Huffman decode of bf16 exponents.
// Flow: table write, push and no-op pass from accept to S_OUT, which loads
//   the result once the output register is free; a decode makes one memory
//   read per chain level (1 to 4), then a length read, all on one read port.
// Throughput: one request at a time; ready returns once the result is loaded.
// Reset (sync, active low) empties the accumulator, sets table_count to 4.
module huffman_exponent_bf16_decoder_unit #(
  parameter int unsigned MAX_TABLES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_table_count,
  // requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_table_address,
  input  logic [7:0]  in_table_byte,
  input  logic [7:0]  in_code_byte,
  input  logic [7:0]  in_sign_mantissa,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic [7:0]  out_code_length,
  output logic [1:0]  out_status
);

  import hebd_pkg::*;

  localparam int unsigned MEM_DEPTH = (MAX_TABLES + 1) * 256;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned TIDX_W    = MEM_AW - 8;

  state_t state_r, state_nxt;

  logic [3:0]  tc_r;
  logic [1:0]  level_r, level_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic [7:0]  sm_r, sm_nxt;
  logic [15:0] res_value_r, res_value_nxt;
  logic [7:0]  res_len_r, res_len_nxt;
  status_t     res_status_r, res_status_nxt;
  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic [7:0]  out_len_r;
  status_t     out_status_r;

  logic              in_fire;
  logic              out_load;
  logic              addr_ok;
  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [MEM_AW-1:0] mem_rd_addr;
  logic [7:0]        mem_rdata;
  acc_cmd_t          acc_cmd;
  logic [1:0]        byte_sel;
  logic [7:0]        acc_byte;
  logic              acc_full;
  logic [TIDX_W-1:0] k;
  logic [8:0]        link_dist;
  logic              link_go;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TBL_CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tc_r <= cfg_table_count;
    end
  end

  // Effective table count, clamped to the tables the memory holds
  always_comb begin
    if (32'(tc_r) > MAX_TABLES) begin
      k = TIDX_W'(MAX_TABLES);
    end else begin
      k = TIDX_W'(tc_r);
    end
  end

  // Chain decision on the entry just read
  assign link_dist = 9'd256 - {1'b0, mem_rdata};
  assign link_go   = (level_r != LEVEL_MAX) && (mem_rdata >= LINK_MIN) &&
                     (32'(link_dist) < 32'(k));

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = !out_valid_r || out_ready;
  assign addr_ok  = 32'(in_table_address) < MEM_DEPTH;
  assign byte_sel = (state_r == S_IDLE) ? 2'd0 : level_r + 2'd1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (op_t'(in_op) == OP_DECODE) ? S_LINK : S_OUT;
        end
      end
      S_LINK: begin
        state_nxt = link_go ? S_LINK : S_LEN;
      end
      S_LEN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = {{TIDX_W{1'b0}}, acc_byte};
    acc_cmd        = '0;
    level_nxt      = level_r;
    exp_nxt        = exp_r;
    sm_nxt         = sm_r;
    res_value_nxt  = res_value_r;
    res_len_nxt    = res_len_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_value_nxt  = '0;
          res_len_nxt    = '0;
          res_status_nxt = STAT_OK;
          unique case (op_t'(in_op))
            OP_WR_TABLE: mem_wr_en = addr_ok;
            OP_PUSH: begin
              if (acc_full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                acc_cmd.push      = 1'b1;
                acc_cmd.push_byte = in_code_byte;
              end
            end
            OP_DECODE: begin
              // first level: top accumulator byte into table 0
              mem_rd_en = 1'b1;
              level_nxt = '0;
              sm_nxt    = in_sign_mantissa;
            end
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      S_LINK: begin
        mem_rd_en = 1'b1;
        if (link_go) begin
          mem_rd_addr = {TIDX_W'(link_dist), acc_byte};
          level_nxt   = level_r + 2'd1;
        end else begin
          // length table entry for the decoded exponent
          mem_rd_addr = {k, mem_rdata};
          exp_nxt     = mem_rdata;
        end
      end
      S_LEN: begin
        if (mem_rdata == 8'd0) begin
          res_status_nxt = STAT_INVALID;
        end else begin
          res_value_nxt    = {sm_r[7], exp_r, sm_r[6:0]};
          res_len_nxt      = mem_rdata;
          acc_cmd.drop     = 1'b1;
          acc_cmd.drop_len = mem_rdata;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    exp_r        <= exp_nxt;
    sm_r         <= sm_nxt;
    res_value_r  <= res_value_nxt;
    res_len_r    <= res_len_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_OUT && out_load) begin
      out_value_r  <= res_value_r;
      out_len_r    <= res_len_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_code_length = out_len_r;
  assign out_status      = out_status_r;

  hebd_lut_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_lut_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (MEM_AW'(in_table_address)),
    .wr_data (in_table_byte),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rdata)
  );

  hebd_bit_acc u_bit_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (acc_cmd),
    .byte_sel (byte_sel),
    .byte_out (acc_byte),
    .full     (acc_full)
  );

endmodule

// ===== sim/huffman_exponent_bf16_decoder_unit_tb.sv =====
// Self-checking testbench for the bf16 exponent Huffman decoder unit.
`timescale 1ns / 1ps

module huffman_exponent_bf16_decoder_unit_tb;
  import hebd_pkg::*;

  localparam int unsigned N_TABLES     = 8;
  localparam int unsigned MEM_DEPTH    = (N_TABLES + 1) * 256;
  localparam int unsigned DRAIN_SLACK  = 8;    // longer than the slowest decode
  localparam int unsigned MAX_REPORTS  = 100;
  localparam longint unsigned RUN_LIMIT_NS = 25_000_000;

  typedef struct packed {
    op_t         op;
    logic [11:0] table_address;
    logic [7:0]  table_byte;
    logic [7:0]  code_byte;
    logic [7:0]  sign_mantissa;
  } request_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  code_length;
    status_t     status;
  } bf16_result_t;

  // DUT connections; the driven inputs are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_table_count = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [11:0] in_table_address = '0;
  logic [7:0]  in_table_byte = '0;
  logic [7:0]  in_code_byte = '0;
  logic [7:0]  in_sign_mantissa = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_value;
  logic [7:0]  out_code_length;
  logic [1:0]  out_status;

  // Predictor state: table memory, bit accumulator, table count
  logic [7:0]  lut_mem     [MEM_DEPTH];
  bit          lut_written [MEM_DEPTH];
  logic [63:0] acc_bits  = '0;
  int unsigned acc_held  = 0;
  logic [3:0]  tbl_count = TBL_CNT_RESET;

  bf16_result_t bf16_results_due [$];
  int unsigned  error_count   = 0;
  int unsigned  requests_sent = 0;
  int unsigned  burst_left    = 0;

  // Receiver stall pattern
  logic [5:0]  ready_phase = '0;
  logic [15:0] ready_mask  = '1;

  huffman_exponent_bf16_decoder_unit #(
    .MAX_TABLES(N_TABLES)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_count  (cfg_table_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_table_address (in_table_address),
    .in_table_byte    (in_table_byte),
    .in_code_byte     (in_code_byte),
    .in_sign_mantissa (in_sign_mantissa),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_code_length  (out_code_length),
    .out_status       (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Effective number of chained tables (counts above the maximum saturate)
  function automatic int unsigned active_tables();
    return (tbl_count > N_TABLES) ? N_TABLES : tbl_count;
  endfunction

  // Walk the decode chain for the current accumulator. Returns 0 with the
  // address of the first unwritten entry on the path, or 1 with the final
  // exponent, its length and the address of that length entry.
  function automatic bit walk_code_chain(output int unsigned entry, output bit for_len,
                                         output logic [7:0] expo, output logic [7:0] len);
    int unsigned k_eff;
    int unsigned lvl;
    k_eff   = active_tables();
    for_len = 1'b0;
    expo    = '0;
    len     = '0;
    entry   = {24'd0, acc_bits[63:56]};
    if (!lut_written[12'(entry)]) return 1'b0;
    expo = lut_mem[12'(entry)];
    for (lvl = 1; lvl < 4; lvl++) begin
      if (expo < LINK_MIN || (256 - expo) >= k_eff) break;
      entry = 256 * (256 - expo) + acc_bits[63 - 8 * lvl -: 8];
      if (!lut_written[12'(entry)]) return 1'b0;
      expo = lut_mem[12'(entry)];
    end
    entry   = 256 * k_eff + expo;
    for_len = 1'b1;
    if (!lut_written[12'(entry)]) return 1'b0;
    len = lut_mem[12'(entry)];
    return 1'b1;
  endfunction

  // Expected result of one accepted request; updates the predictor state
  task automatic predict_bf16_result(input request_t r, output bf16_result_t res);
    int unsigned entry;
    bit          for_len;
    logic [7:0]  expo;
    logic [7:0]  len;
    res.value       = '0;
    res.code_length = '0;
    res.status      = STAT_OK;
    case (r.op)
      OP_WR_TABLE: begin
        if (r.table_address < MEM_DEPTH) begin
          lut_mem[r.table_address]     = r.table_byte;
          lut_written[r.table_address] = 1'b1;
        end
      end
      OP_PUSH: begin
        if (acc_held > FULL_LIMIT) begin
          res.status = STAT_FULL;
        end else begin
          acc_bits = acc_bits | ({56'd0, r.code_byte} << (56 - acc_held));
          acc_held = acc_held + 8;
        end
      end
      OP_DECODE: begin
        if (!walk_code_chain(entry, for_len, expo, len))
          flag_error($sformatf("stimulus decoded through unwritten entry %0d", entry));
        res.code_length = len;
        if (len == 0) begin
          res.status = STAT_INVALID;
        end else begin
          res.value = {r.sign_mantissa[7], expo, r.sign_mantissa[6:0]};
          acc_bits  = (len >= 64) ? 64'd0 : acc_bits << len;
          acc_held  = (len >= acc_held) ? 0 : acc_held - len;
        end
      end
      default: ;
    endcase
  endtask

  function automatic request_t rand_request(input op_t op);
    request_t r;
    r.op            = op;
    r.table_address = 12'($urandom_range(4095));
    r.table_byte    = 8'($urandom_range(255));
    r.code_byte     = 8'($urandom_range(255));
    r.sign_mantissa = 8'($urandom_range(255));
    return r;
  endfunction

  // Sender: bursts of random length, random gaps between them
  task automatic issue_request(input request_t r);
    bf16_result_t want;
    int unsigned  gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_op            <= r.op;
    in_table_address <= r.table_address;
    in_table_byte    <= r.table_byte;
    in_code_byte     <= r.code_byte;
    in_sign_mantissa <= r.sign_mantissa;
    do @(posedge clk); while (!in_ready);
    predict_bf16_result(r, want);
    bf16_results_due.push_back(want);
    if (!(r.op == OP_NONE || (r.op == OP_WR_TABLE && r.table_address >= MEM_DEPTH)))
      requests_sent++;
  endtask

  task automatic write_table(input logic [11:0] addr, input logic [7:0] data);
    request_t r;
    r = rand_request(OP_WR_TABLE);
    r.table_address = addr;
    r.table_byte    = data;
    issue_request(r);
  endtask

  task automatic push_code(input logic [7:0] data);
    request_t r;
    r = rand_request(OP_PUSH);
    r.code_byte = data;
    issue_request(r);
  endtask

  // Mostly short codes, some invalid, some long enough to empty the accumulator;
  // decode entries lean toward link values
  function automatic logic [7:0] pick_table_byte(input bit for_len);
    int unsigned roll;
    roll = $urandom_range(99);
    if (for_len) begin
      if (roll < 5) return 8'd0;
      if (roll < 80) return 8'($urandom_range(1, 12));
      if (roll < 93) return 8'($urandom_range(13, 40));
      return 8'($urandom_range(56, 255));
    end
    if (roll < 30) return 8'(256 - $urandom_range(1, N_TABLES - 1));
    return 8'($urandom_range(255));
  endfunction

  // Decode one element, first filling every entry the chain would reach
  task automatic decode_element(input logic [7:0] sm);
    request_t    r;
    int unsigned entry;
    bit          for_len;
    logic [7:0]  expo;
    logic [7:0]  len;
    while (!walk_code_chain(entry, for_len, expo, len))
      write_table(12'(entry), pick_table_byte(for_len));
    r = rand_request(OP_DECODE);
    r.sign_mantissa = sm;
    issue_request(r);
  endtask

  // Idle the sender until every result is back, then let the block settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (bf16_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_table_count(input logic [3:0] count);
    wait_results_drained();
    cfg_table_count <= count;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_count = count;
  endtask

  task automatic random_request();
    request_t    r;
    int unsigned roll;
    int unsigned entry;
    bit          for_len;
    logic [7:0]  expo;
    logic [7:0]  len;
    roll = $urandom_range(99);
    // keep the accumulator fed when it runs low
    if (acc_held < 8 && roll >= 45 && roll < 80 && $urandom_range(1) == 1) roll = 0;
    if (roll < 45) begin
      push_code(8'($urandom_range(255)));
    end else if (roll < 80) begin
      // repair a stuck invalid code now and then so the stream keeps moving
      if (walk_code_chain(entry, for_len, expo, len) && len == 0 && $urandom_range(1) == 1)
        write_table(12'(entry), 8'($urandom_range(1, 12)));
      decode_element(8'($urandom_range(255)));
    end else if (roll < 90) begin
      r = rand_request(OP_WR_TABLE);
      r.table_address = 12'($urandom_range(MEM_DEPTH - 1));
      r.table_byte    = pick_table_byte((r.table_address >> 8) == active_tables());
      issue_request(r);
    end else if (roll < 95) begin
      r = rand_request(OP_WR_TABLE);
      r.table_address = 12'($urandom_range(MEM_DEPTH, 4095));
      issue_request(r);
    end else begin
      issue_request(rand_request(OP_NONE));
    end
  endtask

  task automatic run_random_requests(input int unsigned count);
    int unsigned target;
    target = requests_sent + count;
    while (requests_sent < target) random_request();
  endtask

  // Out-of-range writes and the unused opcode
  task automatic test_odd_requests();
    request_t r;
    write_table(MEM_DEPTH, 8'hFF);
    write_table(12'hFFF, 8'h5A);
    r = '{op: OP_NONE, table_address: '1, table_byte: '1, code_byte: '1, sign_mantissa: '1};
    issue_request(r);
    r = '{op: OP_NONE, table_address: '0, table_byte: '0, code_byte: '0, sign_mantissa: '0};
    issue_request(r);
  endtask

  // Four-level chain, full accumulator, long code, invalid code (table count 4)
  task automatic test_chain_levels();
    write_table(12'h011, 8'd255);          // table 0 -> table 1
    write_table(12'h122, 8'd254);          // table 1 -> table 2
    write_table(12'h233, 8'd253);          // table 2 -> table 3
    write_table(12'h344, 8'h00);
    write_table(12'h345, 8'd255);          // link value at the last level is the exponent
    write_table(12'h400, 8'd32);
    write_table(12'h4FF, 8'd70);           // past 64 bits: clears everything
    push_code(8'h11); push_code(8'h22); push_code(8'h33); push_code(8'h44);
    push_code(8'h11); push_code(8'h22); push_code(8'h33); push_code(8'h45);
    push_code(8'hFF);                      // refused, 64 bits held
    decode_element(8'hFF);
    decode_element(8'h80);                 // longer than what is held
    write_table(12'h000, 8'h7E);
    write_table(12'h47E, 8'h00);
    decode_element(8'h7F);                 // zero length: invalid, nothing consumed
  endtask

  // Extremes of the table count, including zero and past the maximum
  task automatic test_table_count_sweep();
    logic [3:0] sweep_counts [5];
    sweep_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2};
    foreach (sweep_counts[i]) begin
      set_table_count(sweep_counts[i]);
      run_random_requests(120);
    end
  endtask

  // Random table counts; the sender also pauses mid-phase until all results are in
  task automatic test_random_traffic();
    repeat (5) begin
      set_table_count(4'($urandom_range(1, N_TABLES)));
      run_random_requests(95);
      wait_results_drained();
      run_random_requests(95);
    end
  endtask

  // Receiver: a fresh stall mask each time the phase counter wraps, sometimes no stalls at all
  always @(posedge clk) begin
    if (ready_phase == 0)
      ready_mask = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom | 16'h0001);
    out_ready <= ready_mask[ready_phase[3:0]];
    ready_phase = ready_phase + 6'd1;
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    bf16_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bf16_results_due.size() == 0) begin
        flag_error($sformatf("result with none due: value %h length %0d status %0d",
                             out_value, out_code_length, out_status));
      end else begin
        want = bf16_results_due.pop_front();
        if (out_value !== want.value)
          flag_error($sformatf("value got %h want %h", out_value, want.value));
        if (out_code_length !== want.code_length)
          flag_error($sformatf("code_length got %0d want %0d", out_code_length,
                               want.code_length));
        if (out_status !== want.status)
          flag_error($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_odd_requests();
    test_chain_levels();
    test_table_count_sweep();
    test_random_traffic();
    wait_results_drained();
    if (error_count == 0)
      $display("** huffman_exponent_bf16_decoder_unit: PASSED **");
    else
      $display("** huffman_exponent_bf16_decoder_unit: FAILED **");
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("** huffman_exponent_bf16_decoder_unit: FAILED **");
    $finish;
  end

endmodule
